// ===== rtl/core/wcs_pkg.sv =====
// Shared definitions for the wash cycle sequencer: phase and program codes,
// register indexes, reset values, the configuration bundle and program timing tables.
// No dependencies; the design files refer to it by scoped names, the testbench imports it.
package wcs_pkg;

    localparam int MASS_BITS_DEF = 10;
    localparam int THR_BITS      = 10;
    localparam int TICK_BITS     = 16;
    localparam int SEC_BITS      = 8;
    localparam int PHASE_BITS    = 4;
    localparam int PROG_BITS     = 2;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;
    localparam int BTN_BITS      = 4;

    // Phase codes, also reported on the result channel.
    localparam logic [PHASE_BITS-1:0] PH_MENU   = 4'd0;
    localparam logic [PHASE_BITS-1:0] PH_DOOR   = 4'd1;
    localparam logic [PHASE_BITS-1:0] PH_FILL   = 4'd2;
    localparam logic [PHASE_BITS-1:0] PH_OVER   = 4'd3;
    localparam logic [PHASE_BITS-1:0] PH_SETTLE = 4'd4;
    localparam logic [PHASE_BITS-1:0] PH_DISP   = 4'd5;
    localparam logic [PHASE_BITS-1:0] PH_AGIT   = 4'd6;
    localparam logic [PHASE_BITS-1:0] PH_DRAIN  = 4'd7;
    localparam logic [PHASE_BITS-1:0] PH_SPIN   = 4'd8;
    localparam logic [PHASE_BITS-1:0] PH_STOPD  = 4'd9;

    // Program codes.
    localparam logic [PROG_BITS-1:0] PROG_NORMAL   = 2'd1;
    localparam logic [PROG_BITS-1:0] PROG_DELICATE = 2'd2;
    localparam logic [PROG_BITS-1:0] PROG_QUICK    = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] REG_FILL_LOW_LARGE   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_FILL_HIGH_LARGE  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_FILL_LOW_SMALL   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_FILL_HIGH_SMALL  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_TICKS_PER_SECOND = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_DISPENSE_SECONDS = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_SETTLE_TICKS     = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_STOP_DRAIN_TICKS = 3'd7;

    // Reset values of the configuration registers.
    localparam logic [THR_BITS-1:0]  RST_FILL_LOW_LARGE   = 10'd926;
    localparam logic [THR_BITS-1:0]  RST_FILL_HIGH_LARGE  = 10'd936;
    localparam logic [THR_BITS-1:0]  RST_FILL_LOW_SMALL   = 10'd682;
    localparam logic [THR_BITS-1:0]  RST_FILL_HIGH_SMALL  = 10'd692;
    localparam logic [THR_BITS-1:0]  RST_TICKS_PER_SECOND = 10'd100;
    localparam logic [SEC_BITS-1:0]  RST_DISPENSE_SECONDS = 8'd2;
    localparam logic [TICK_BITS-1:0] RST_SETTLE_TICKS     = 16'd100;
    localparam logic [TICK_BITS-1:0] RST_STOP_DRAIN_TICKS = 16'd100;

    typedef struct packed {
        logic [THR_BITS-1:0]  fill_low_large;
        logic [THR_BITS-1:0]  fill_high_large;
        logic [THR_BITS-1:0]  fill_low_small;
        logic [THR_BITS-1:0]  fill_high_small;
        logic [THR_BITS-1:0]  ticks_per_second;
        logic [SEC_BITS-1:0]  dispense_seconds;
        logic [TICK_BITS-1:0] settle_ticks;
        logic [TICK_BITS-1:0] stop_drain_ticks;
    } cfg_t;

    // Seconds loaded on entry to a timed phase; zero for phases that count ticks or wait.
    function automatic logic [SEC_BITS-1:0] phase_seconds(
        input logic [PHASE_BITS-1:0] ph,
        input logic [PROG_BITS-1:0]  prog,
        input logic                  rinse,
        input logic [SEC_BITS-1:0]   disp
    );
        logic [SEC_BITS-1:0] wash_s;
        logic [SEC_BITS-1:0] rinse_s;
        logic [SEC_BITS-1:0] spin_s;
        case (prog)
            PROG_DELICATE: begin wash_s = 8'd3; rinse_s = 8'd1; spin_s = 8'd1; end
            PROG_QUICK:    begin wash_s = 8'd4; rinse_s = 8'd2; spin_s = 8'd1; end
            default:       begin wash_s = 8'd5; rinse_s = 8'd3; spin_s = 8'd2; end
        endcase
        case (ph)
            PH_DISP:           phase_seconds = disp;
            PH_AGIT, PH_DRAIN: phase_seconds = rinse ? rinse_s : wash_s;
            PH_SPIN:           phase_seconds = spin_s;
            default:           phase_seconds = '0;
        endcase
    endfunction

endpackage

// ===== rtl/core/wash_cycle_sequencer.sv =====
// Top level of the wash cycle sequencer: configuration registers and sequencer core.
// Depends on wcs_pkg, wcs_cfg and wcs_core.
//
//  Channel  | Direction | Ports                               | Contents
//  ---------+-----------+-------------------------------------+-------------------------------
//  s_       | in        | s_tvalid, s_tready, s_tdata         | one 10 ms tick of sampled pins
//  m_       | out       | m_tvalid, m_tready, m_tdata         | LED, actuator, phase, program
//  cfg_     | in        | cfg_wr_en, cfg_index, cfg_wdata     | register writes, no read-back
//
// The step is computed between the sequencer state registers and the result register,
// so a new transaction is accepted every cycle while the result register is empty or
// is being emptied in the same cycle.
// A valid result appears in the cycle after input acceptance.
// Reset (aresetn low at a clock edge) puts the sequencer in the menu with the normal
// program selected and loads the configuration reset values; no clearing pass follows.
// A stalled result holds the input side off (s_tready low) until it is taken.
module wash_cycle_sequencer #(
    parameter int MASS_BITS = wcs_pkg::MASS_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Register writes: index selects the register in list order.
    input  logic                              cfg_wr_en,
    input  logic [wcs_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [wcs_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
    // Input transaction.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata from bit 0: up_pressed, down_pressed, enter_pressed, stop_pressed,
    // door_closed, mass_sample[MASS_BITS-1:0], zero fill.
    input  logic [((5 + MASS_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // Result transaction.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata from bit 0: wash_led, rinse_led, dispense_led, spin_lamp, door_lock,
    // motor_on, inlet_open, outlet_open, phase[3:0], program_choice[1:0], zero fill.
    output logic [15:0]                       m_tdata
);

    localparam int IN_W  = ((5 + MASS_BITS + 7) / 8) * 8;
    localparam int OUT_W = 16;

    wcs_pkg::cfg_t cfg;

    wcs_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // The core applies each accepted tick to the sequencer and registers the result.
    wcs_core #(
        .MASS_BITS (MASS_BITS),
        .IN_W      (IN_W),
        .OUT_W     (OUT_W)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== rtl/core/wcs_cfg.sv =====
// Configuration register file of the wash cycle sequencer.
// Depends on wcs_pkg for register indexes, reset values and the cfg_t bundle.
module wcs_cfg (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [wcs_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [wcs_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
    output wcs_pkg::cfg_t                     cfg
);

    wcs_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.fill_low_large   <= wcs_pkg::RST_FILL_LOW_LARGE;
            cfg_reg.fill_high_large  <= wcs_pkg::RST_FILL_HIGH_LARGE;
            cfg_reg.fill_low_small   <= wcs_pkg::RST_FILL_LOW_SMALL;
            cfg_reg.fill_high_small  <= wcs_pkg::RST_FILL_HIGH_SMALL;
            cfg_reg.ticks_per_second <= wcs_pkg::RST_TICKS_PER_SECOND;
            cfg_reg.dispense_seconds <= wcs_pkg::RST_DISPENSE_SECONDS;
            cfg_reg.settle_ticks     <= wcs_pkg::RST_SETTLE_TICKS;
            cfg_reg.stop_drain_ticks <= wcs_pkg::RST_STOP_DRAIN_TICKS;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                wcs_pkg::REG_FILL_LOW_LARGE:
                    cfg_reg.fill_low_large <= cfg_wdata[wcs_pkg::THR_BITS-1:0];
                wcs_pkg::REG_FILL_HIGH_LARGE:
                    cfg_reg.fill_high_large <= cfg_wdata[wcs_pkg::THR_BITS-1:0];
                wcs_pkg::REG_FILL_LOW_SMALL:
                    cfg_reg.fill_low_small <= cfg_wdata[wcs_pkg::THR_BITS-1:0];
                wcs_pkg::REG_FILL_HIGH_SMALL:
                    cfg_reg.fill_high_small <= cfg_wdata[wcs_pkg::THR_BITS-1:0];
                wcs_pkg::REG_TICKS_PER_SECOND:
                    cfg_reg.ticks_per_second <= cfg_wdata[wcs_pkg::THR_BITS-1:0];
                wcs_pkg::REG_DISPENSE_SECONDS:
                    cfg_reg.dispense_seconds <= cfg_wdata[wcs_pkg::SEC_BITS-1:0];
                wcs_pkg::REG_SETTLE_TICKS:
                    cfg_reg.settle_ticks <= cfg_wdata[wcs_pkg::TICK_BITS-1:0];
                wcs_pkg::REG_STOP_DRAIN_TICKS:
                    cfg_reg.stop_drain_ticks <= cfg_wdata[wcs_pkg::TICK_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/wcs_core.sv =====
// Sequencer state, next-state logic and registered result of the wash cycle sequencer.
// Depends on wcs_pkg for phase and program codes, the cfg_t bundle and phase_seconds.
module wcs_core #(
    parameter int MASS_BITS = wcs_pkg::MASS_BITS_DEF,
    parameter int IN_W      = 16,
    parameter int OUT_W     = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  wcs_pkg::cfg_t     cfg,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata
);

    localparam int CMP_W = (MASS_BITS > wcs_pkg::THR_BITS) ? MASS_BITS : wcs_pkg::THR_BITS;
    localparam int RES_W = 8 + wcs_pkg::PHASE_BITS + wcs_pkg::PROG_BITS;

    logic [wcs_pkg::PHASE_BITS-1:0] phase_reg,  phase_next;
    logic [wcs_pkg::PROG_BITS-1:0]  prog_reg,   prog_next;
    logic                           rinse_reg,  rinse_next;
    logic [wcs_pkg::TICK_BITS-1:0]  tick_reg,   tick_next;
    logic [wcs_pkg::SEC_BITS-1:0]   sec_reg,    sec_next;
    logic [wcs_pkg::BTN_BITS-1:0]   btn_reg;
    logic                           lock_reg,   lock_next;
    logic                           valid_reg;
    logic [OUT_W-1:0]               data_reg;

    logic                           accept;
    logic [wcs_pkg::BTN_BITS-1:0]   btn;
    logic [wcs_pkg::BTN_BITS-1:0]   rise;
    logic                           ev_up, ev_down, ev_enter, ev_stop;
    logic                           door;
    logic [CMP_W-1:0]               mass;
    logic [CMP_W-1:0]               lo, hi;
    logic [wcs_pkg::TICK_BITS-1:0]  tick_inc;
    logic [wcs_pkg::TICK_BITS-1:0]  tps;
    logic [wcs_pkg::TICK_BITS-1:0]  tick_len;
    logic [wcs_pkg::SEC_BITS-1:0]   sec_dec;
    logic                           do_enter;
    logic [wcs_pkg::PHASE_BITS-1:0] tgt;
    logic                           pass_on;
    logic [RES_W-1:0]               result;

    assign accept = s_tvalid && s_tready;
    assign s_tready = !valid_reg || m_tready;

    assign btn  = s_tdata[wcs_pkg::BTN_BITS-1:0];
    assign rise = btn & ~btn_reg;
    // Only the highest-priority rising edge of the step counts.
    assign ev_up    = rise[0];
    assign ev_down  = !rise[0] && rise[1];
    assign ev_enter = !rise[0] && !rise[1] && rise[2];
    assign ev_stop  = !rise[0] && !rise[1] && !rise[2] && rise[3];
    assign door = s_tdata[4];
    assign mass = CMP_W'(s_tdata[5 +: MASS_BITS]);

    assign lo = (prog_reg == wcs_pkg::PROG_NORMAL) ? CMP_W'(cfg.fill_low_large)
                                                   : CMP_W'(cfg.fill_low_small);
    assign hi = (prog_reg == wcs_pkg::PROG_NORMAL) ? CMP_W'(cfg.fill_high_large)
                                                   : CMP_W'(cfg.fill_high_small);

    assign tick_inc = tick_reg + 1'b1;
    assign tps = (cfg.ticks_per_second == '0) ? wcs_pkg::TICK_BITS'(1)
                                              : wcs_pkg::TICK_BITS'(cfg.ticks_per_second);
    assign tick_len = (phase_reg == wcs_pkg::PH_SETTLE) ? cfg.settle_ticks
                                                        : cfg.stop_drain_ticks;
    assign sec_dec = (sec_reg != '0) ? sec_reg - 1'b1 : sec_reg;

    always_comb begin
        phase_next = phase_reg;
        prog_next  = prog_reg;
        rinse_next = rinse_reg;
        tick_next  = tick_reg;
        sec_next   = sec_reg;
        lock_next  = lock_reg;
        do_enter   = 1'b0;
        tgt        = wcs_pkg::PH_MENU;

        unique case (phase_reg)
            wcs_pkg::PH_MENU: begin
                if (ev_up) begin
                    if (prog_reg == wcs_pkg::PROG_QUICK)
                        prog_next = wcs_pkg::PROG_DELICATE;
                    else if (prog_reg == wcs_pkg::PROG_DELICATE)
                        prog_next = wcs_pkg::PROG_NORMAL;
                end else if (ev_down) begin
                    if (prog_reg == wcs_pkg::PROG_NORMAL)
                        prog_next = wcs_pkg::PROG_DELICATE;
                    else if (prog_reg == wcs_pkg::PROG_DELICATE)
                        prog_next = wcs_pkg::PROG_QUICK;
                end else if (ev_enter) begin
                    rinse_next = 1'b0;
                    do_enter   = 1'b1;
                    tgt        = wcs_pkg::PH_DOOR;
                end else if (ev_stop) begin
                    prog_next = wcs_pkg::PROG_NORMAL;
                end
            end
            wcs_pkg::PH_DOOR, wcs_pkg::PH_FILL, wcs_pkg::PH_OVER, wcs_pkg::PH_SETTLE,
            wcs_pkg::PH_DISP, wcs_pkg::PH_AGIT, wcs_pkg::PH_DRAIN, wcs_pkg::PH_SPIN,
            wcs_pkg::PH_STOPD: begin
                if (ev_stop && phase_reg != wcs_pkg::PH_STOPD) begin
                    do_enter = 1'b1;
                    tgt      = wcs_pkg::PH_STOPD;
                end else if (phase_reg == wcs_pkg::PH_DOOR) begin
                    if (door) begin
                        do_enter = 1'b1;
                        if (mass <= lo)
                            tgt = wcs_pkg::PH_FILL;
                        else if (mass > hi)
                            tgt = wcs_pkg::PH_OVER;
                        else
                            tgt = wcs_pkg::PH_SETTLE;
                    end
                end else if (phase_reg == wcs_pkg::PH_FILL) begin
                    if (mass > lo) begin
                        do_enter = 1'b1;
                        tgt = (mass > hi) ? wcs_pkg::PH_OVER : wcs_pkg::PH_SETTLE;
                    end
                end else if (phase_reg == wcs_pkg::PH_OVER) begin
                    if (mass <= hi) begin
                        do_enter = 1'b1;
                        tgt      = wcs_pkg::PH_SETTLE;
                    end
                end else if (phase_reg == wcs_pkg::PH_SETTLE ||
                             phase_reg == wcs_pkg::PH_STOPD) begin
                    // Tick-counted phases.
                    tick_next = tick_inc;
                    if (tick_inc >= tick_len) begin
                        do_enter = 1'b1;
                        if (phase_reg == wcs_pkg::PH_STOPD)
                            tgt = wcs_pkg::PH_MENU;
                        else
                            tgt = rinse_reg ? wcs_pkg::PH_AGIT : wcs_pkg::PH_DISP;
                    end
                end else begin
                    // Second-counted phases: dispense, agitate, drain and spin.
                    tick_next = tick_inc;
                    if (tick_inc >= tps) begin
                        tick_next = '0;
                        sec_next  = sec_dec;
                        if (sec_dec == '0) begin
                            do_enter = 1'b1;
                            unique case (phase_reg)
                                wcs_pkg::PH_DISP: tgt = wcs_pkg::PH_AGIT;
                                wcs_pkg::PH_AGIT: tgt = wcs_pkg::PH_DRAIN;
                                wcs_pkg::PH_DRAIN: begin
                                    if (!rinse_reg) begin
                                        // The wash pass is over: unlock and start rinse.
                                        rinse_next = 1'b1;
                                        lock_next  = 1'b0;
                                        tgt        = wcs_pkg::PH_DOOR;
                                    end else begin
                                        tgt = wcs_pkg::PH_SPIN;
                                    end
                                end
                                default: tgt = wcs_pkg::PH_MENU;
                            endcase
                        end
                    end
                end
            end
            default: begin
                do_enter = 1'b1;
                tgt      = wcs_pkg::PH_MENU;
            end
        endcase

        // Phase entry, skipping phases whose length is zero within the same step.
        if (do_enter) begin
            tick_next = '0;
            if (tgt == wcs_pkg::PH_SETTLE) begin
                lock_next = 1'b1;
                if (cfg.settle_ticks == '0)
                    tgt = rinse_next ? wcs_pkg::PH_AGIT : wcs_pkg::PH_DISP;
            end
            if (tgt == wcs_pkg::PH_DISP && cfg.dispense_seconds == '0)
                tgt = wcs_pkg::PH_AGIT;
            if (tgt == wcs_pkg::PH_STOPD && cfg.stop_drain_ticks == '0)
                tgt = wcs_pkg::PH_MENU;
            if (tgt == wcs_pkg::PH_MENU) begin
                prog_next  = wcs_pkg::PROG_NORMAL;
                rinse_next = 1'b0;
                lock_next  = 1'b0;
            end
            phase_next = tgt;
            sec_next   = wcs_pkg::phase_seconds(tgt, prog_next, rinse_next,
                                                cfg.dispense_seconds);
        end
    end

    assign pass_on = (phase_next >= wcs_pkg::PH_SETTLE) && (phase_next <= wcs_pkg::PH_DRAIN);
    assign result = {
        prog_next,
        phase_next,
        (phase_next == wcs_pkg::PH_DRAIN) || (phase_next == wcs_pkg::PH_SPIN) ||
            (phase_next == wcs_pkg::PH_STOPD),
        (phase_next == wcs_pkg::PH_DOOR) || (phase_next == wcs_pkg::PH_FILL) ||
            (phase_next == wcs_pkg::PH_OVER),
        (phase_next == wcs_pkg::PH_AGIT) || (phase_next == wcs_pkg::PH_SPIN),
        lock_next,
        phase_next == wcs_pkg::PH_SPIN,
        phase_next == wcs_pkg::PH_DISP,
        pass_on && rinse_next,
        pass_on && !rinse_next
    };

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= wcs_pkg::PH_MENU;
            prog_reg  <= wcs_pkg::PROG_NORMAL;
            rinse_reg <= 1'b0;
            tick_reg  <= '0;
            sec_reg   <= '0;
            btn_reg   <= '0;
            lock_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg <= phase_next;
                prog_reg  <= prog_next;
                rinse_reg <= rinse_next;
                tick_reg  <= tick_next;
                sec_reg   <= sec_next;
                btn_reg   <= btn;
                lock_reg  <= lock_next;
                valid_reg <= 1'b1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept)
            data_reg <= OUT_W'(result);
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

// ===== bench/tb_wash_cycle_sequencer.sv =====
// Self-checking testbench for the wash cycle sequencer: streams sampled pin ticks,
// predicts every panel and actuator word in its own sequencer model and compares them.
// Depends on wcs_pkg and the wash_cycle_sequencer top level.
`timescale 1ns / 100ps

module tb_wash_cycle_sequencer;

    import wcs_pkg::*;

    localparam int MASS_BITS   = MASS_BITS_DEF;
    localparam int MASS_MAX    = (1 << MASS_BITS) - 1;
    localparam int S_WIDTH     = ((5 + MASS_BITS + 7) / 8) * 8;
    localparam int STALL_LIMIT = 2000;
    localparam int ROUNDS      = 4;
    localparam int ROUND_TICKS = 90;

    // One sampled tick of the pins, packed exactly as s_tdata carries it.
    typedef struct packed {
        logic [S_WIDTH-6-MASS_BITS:0] pad;
        logic [MASS_BITS-1:0]         mass;
        logic                         door;
        logic                         stop_btn;
        logic                         enter_btn;
        logic                         down_btn;
        logic                         up_btn;
    } pin_sample_t;

    // The panel and actuator word, packed exactly as m_tdata carries it.
    typedef struct packed {
        logic [1:0]            pad;
        logic [PROG_BITS-1:0]  program_choice;
        logic [PHASE_BITS-1:0] phase;
        logic                  outlet_open;
        logic                  inlet_open;
        logic                  motor_on;
        logic                  door_lock;
        logic                  spin_lamp;
        logic                  dispense_led;
        logic                  rinse_led;
        logic                  wash_led;
    } panel_word_t;

    // Button event after edge detection and priority selection.
    typedef enum logic [2:0] {
        EVT_NONE,
        EVT_UP,
        EVT_DOWN,
        EVT_ENTER,
        EVT_STOP
    } button_event_e;

    logic                     aclk;
    logic                     aresetn   = 1'b0;
    logic                     cfg_wr_en = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;
    logic                     s_tvalid  = 1'b0;
    logic                     s_tready;
    logic [S_WIDTH-1:0]       s_tdata   = '0;
    logic                     m_tvalid;
    logic                     m_tready  = 1'b0;
    logic [15:0]              m_tdata;

    // Pin ticks waiting for the driver, and panel words waiting for the monitor.
    pin_sample_t sample_queue[$];
    panel_word_t expected_panel[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;
    int quiet_cycles   = 0;
    int samples_queued = 0;

    // Shadow of the configuration registers as written through the port.
    cfg_t shadow_cfg;

    // Sequencer state as the model sees it.
    logic [PHASE_BITS-1:0] seq_phase;
    logic [PROG_BITS-1:0]  seq_prog;
    logic                  seq_rinse;
    logic [TICK_BITS-1:0]  seq_ticks;
    logic [SEC_BITS-1:0]   seq_secs;
    logic [BTN_BITS-1:0]   seq_buttons;
    logic                  seq_lock;

    wash_cycle_sequencer #(
        .MASS_BITS(MASS_BITS)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        // From bit 0: up, down, enter, stop, door_closed, mass_sample, zero fill.
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        // From bit 0: wash, rinse, dispense, spin, door_lock, motor, inlet, outlet,
        // phase, program_choice, zero fill.
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Sequencer model
    // ------------------------------------------------------------------

    // Length of a timed phase: ticks for settle and stop drain, seconds otherwise.
    // Any program code outside the three known ones times like the normal program.
    function automatic int unsigned timed_length(logic [PHASE_BITS-1:0] ph);
        int unsigned wash_s;
        int unsigned rinse_s;
        int unsigned spin_s;
        case (seq_prog)
            PROG_DELICATE: begin
                wash_s = 3; rinse_s = 1; spin_s = 1;
            end
            PROG_QUICK: begin
                wash_s = 4; rinse_s = 2; spin_s = 1;
            end
            default: begin
                wash_s = 5; rinse_s = 3; spin_s = 2;
            end
        endcase
        case (ph)
            PH_SETTLE:         return shadow_cfg.settle_ticks;
            PH_DISP:           return shadow_cfg.dispense_seconds;
            PH_AGIT, PH_DRAIN: return seq_rinse ? rinse_s : wash_s;
            PH_SPIN:           return spin_s;
            PH_STOPD:          return shadow_cfg.stop_drain_ticks;
            default:           return 0;
        endcase
    endfunction

    // Successor of a timed phase. Leaving the wash drain starts the rinse pass
    // and releases the door lock until the next settle.
    function automatic logic [PHASE_BITS-1:0] phase_successor(logic [PHASE_BITS-1:0] ph);
        case (ph)
            PH_SETTLE: return seq_rinse ? PH_AGIT : PH_DISP;
            PH_DISP:   return PH_AGIT;
            PH_AGIT:   return PH_DRAIN;
            PH_DRAIN: begin
                if (!seq_rinse) begin
                    seq_rinse = 1'b1;
                    seq_lock  = 1'b0;
                    return PH_DOOR;
                end
                return PH_SPIN;
            end
            default:   return PH_MENU;
        endcase
    endfunction

    // Enter a phase; a timed phase of zero length falls through to its successor
    // within the same tick.
    function automatic void move_to(logic [PHASE_BITS-1:0] ph);
        bit          settled;
        int unsigned len;
        settled = 1'b0;
        while (!settled) begin
            seq_phase = ph;
            seq_ticks = '0;
            seq_secs  = '0;
            if (ph == PH_MENU) begin
                seq_prog  = PROG_NORMAL;
                seq_rinse = 1'b0;
                seq_lock  = 1'b0;
                settled   = 1'b1;
            end else if (ph == PH_DOOR || ph == PH_FILL || ph == PH_OVER) begin
                settled = 1'b1;
            end else begin
                if (ph == PH_SETTLE) begin
                    seq_lock = 1'b1;
                end
                len = timed_length(ph);
                if (len == 0) begin
                    ph = phase_successor(ph);
                end else begin
                    if (ph != PH_SETTLE && ph != PH_STOPD) begin
                        seq_secs = len[SEC_BITS-1:0];
                    end
                    settled = 1'b1;
                end
            end
        end
    endfunction

    // One tick of a timed phase. Settle and stop drain count raw ticks; the
    // others count seconds of ticks_per_second ticks each, zero acting as one.
    function automatic void count_tick();
        logic [PHASE_BITS-1:0] ph;
        int unsigned           tps;
        ph        = seq_phase;
        seq_ticks = seq_ticks + 1'b1;
        if (ph == PH_SETTLE || ph == PH_STOPD) begin
            if (seq_ticks >= timed_length(ph)) begin
                move_to(phase_successor(ph));
            end
        end else begin
            tps = (shadow_cfg.ticks_per_second == '0) ? 1 : shadow_cfg.ticks_per_second;
            if (seq_ticks >= tps) begin
                seq_ticks = '0;
                if (seq_secs > 0) begin
                    seq_secs = seq_secs - 1'b1;
                end
                if (seq_secs == 0) begin
                    move_to(phase_successor(ph));
                end
            end
        end
    endfunction

    function automatic logic [THR_BITS-1:0] low_mark();
        return (seq_prog == PROG_NORMAL) ? shadow_cfg.fill_low_large : shadow_cfg.fill_low_small;
    endfunction

    function automatic logic [THR_BITS-1:0] high_mark();
        return (seq_prog == PROG_NORMAL) ? shadow_cfg.fill_high_large : shadow_cfg.fill_high_small;
    endfunction

    // Advance the model by one tick and return the panel word it reports.
    function automatic panel_word_t sequencer_step(pin_sample_t s);
        logic [BTN_BITS-1:0] levels;
        logic [BTN_BITS-1:0] rising;
        button_event_e       evt;
        int unsigned         m;
        bit                  pass_on;
        panel_word_t         o;
        levels = {s.stop_btn, s.enter_btn, s.down_btn, s.up_btn};
        rising = levels & ~seq_buttons;
        // Only one new press counts per tick: up, then down, enter, stop.
        if (rising[0]) begin
            evt = EVT_UP;
        end else if (rising[1]) begin
            evt = EVT_DOWN;
        end else if (rising[2]) begin
            evt = EVT_ENTER;
        end else if (rising[3]) begin
            evt = EVT_STOP;
        end else begin
            evt = EVT_NONE;
        end
        m           = s.mass;
        seq_buttons = levels;

        if (seq_phase == PH_MENU) begin
            case (evt)
                EVT_UP: begin
                    if (seq_prog == PROG_QUICK) begin
                        seq_prog = PROG_DELICATE;
                    end else if (seq_prog == PROG_DELICATE) begin
                        seq_prog = PROG_NORMAL;
                    end
                end
                EVT_DOWN: begin
                    if (seq_prog == PROG_NORMAL) begin
                        seq_prog = PROG_DELICATE;
                    end else if (seq_prog == PROG_DELICATE) begin
                        seq_prog = PROG_QUICK;
                    end
                end
                EVT_ENTER: begin
                    seq_rinse = 1'b0;
                    move_to(PH_DOOR);
                end
                EVT_STOP: begin
                    seq_prog = PROG_NORMAL;
                end
                default: begin
                end
            endcase
        end else if (seq_phase == PH_STOPD) begin
            // A second stop is ignored; the drain just keeps counting.
            count_tick();
        end else if (seq_phase >= PH_DOOR && seq_phase <= PH_SPIN) begin
            if (evt == EVT_STOP) begin
                move_to(PH_STOPD);
            end else if (seq_phase == PH_DOOR) begin
                if (s.door) begin
                    if (m <= low_mark()) begin
                        move_to(PH_FILL);
                    end else if (m > high_mark()) begin
                        move_to(PH_OVER);
                    end else begin
                        move_to(PH_SETTLE);
                    end
                end
            end else if (seq_phase == PH_FILL) begin
                if (m > low_mark()) begin
                    move_to((m > high_mark()) ? PH_OVER : PH_SETTLE);
                end
            end else if (seq_phase == PH_OVER) begin
                if (m <= high_mark()) begin
                    move_to(PH_SETTLE);
                end
            end else begin
                count_tick();
            end
        end else begin
            move_to(PH_MENU);
        end

        pass_on          = (seq_phase >= PH_SETTLE && seq_phase <= PH_DRAIN);
        o                = '0;
        o.wash_led       = pass_on && !seq_rinse;
        o.rinse_led      = pass_on && seq_rinse;
        o.dispense_led   = (seq_phase == PH_DISP);
        o.spin_lamp      = (seq_phase == PH_SPIN);
        o.door_lock      = seq_lock;
        o.motor_on       = (seq_phase == PH_AGIT || seq_phase == PH_SPIN);
        o.inlet_open     = (seq_phase == PH_DOOR || seq_phase == PH_FILL ||
                            seq_phase == PH_OVER);
        o.outlet_open    = (seq_phase == PH_DRAIN || seq_phase == PH_SPIN ||
                            seq_phase == PH_STOPD);
        o.phase          = seq_phase;
        o.program_choice = seq_prog;
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Driver, monitor and watchdog
    // ------------------------------------------------------------------

    // The driver predicts each input transaction at the edge that accepts it,
    // then offers the next queued tick unless the queue is empty or this cycle is a gap.
    // tvalid only drops while nothing is being held for the block.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_panel.push_back(sequencer_step(pin_sample_t'(s_tdata)));
            end
            if (!s_tvalid || s_tready) begin
                if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_tdata  <= sample_queue.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // The monitor compares every accepted result transaction with the oldest
    // prediction and picks the back-pressure for the next cycle.
    panel_word_t want_word;
    panel_word_t got_word;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got_word = panel_word_t'(m_tdata);
                if (expected_panel.size() == 0) begin
                    $error("result transaction 0x%h arrived with nothing predicted", m_tdata);
                    mismatch_count++;
                end else begin
                    want_word = expected_panel.pop_front();
                    check_field("wash_led", want_word.wash_led, got_word.wash_led);
                    check_field("rinse_led", want_word.rinse_led, got_word.rinse_led);
                    check_field("dispense_led", want_word.dispense_led,
                                got_word.dispense_led);
                    check_field("spin_lamp", want_word.spin_lamp, got_word.spin_lamp);
                    check_field("door_lock", want_word.door_lock, got_word.door_lock);
                    check_field("motor_on", want_word.motor_on, got_word.motor_on);
                    check_field("inlet_open", want_word.inlet_open, got_word.inlet_open);
                    check_field("outlet_open", want_word.outlet_open, got_word.outlet_open);
                    check_field("phase", want_word.phase, got_word.phase);
                    check_field("program_choice", want_word.program_choice,
                                got_word.program_choice);
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Ends the run when no transaction moves on either side for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles < STALL_LIMIT) begin
            quiet_cycles <= quiet_cycles + 1;
        end else begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic queue_tick(bit up_b, bit down_b, bit enter_b, bit stop_b, bit door_b,
                              int unsigned mass_v);
        pin_sample_t s;
        s           = '0;
        s.up_btn    = up_b;
        s.down_btn  = down_b;
        s.enter_btn = enter_b;
        s.stop_btn  = stop_b;
        s.door      = door_b;
        s.mass      = mass_v[MASS_BITS-1:0];
        sample_queue.push_back(s);
        samples_queued++;
    endtask

    // Mass samples cluster around the current fill thresholds so that every
    // fill decision is taken from both sides.
    function automatic int unsigned pick_mass();
        int unsigned mark;
        int          v;
        case ($urandom_range(7))
            0:       return 0;
            1:       return MASS_MAX;
            2, 3:    return $urandom_range(MASS_MAX);
            default: begin
                case ($urandom_range(3))
                    0:       mark = shadow_cfg.fill_low_large;
                    1:       mark = shadow_cfg.fill_high_large;
                    2:       mark = shadow_cfg.fill_low_small;
                    default: mark = shadow_cfg.fill_high_small;
                endcase
                v = int'(mark) + int'($urandom_range(2)) - 1;
                if (v < 0) begin
                    v = 0;
                end else if (v > MASS_MAX) begin
                    v = MASS_MAX;
                end
                return v;
            end
        endcase
    endfunction

    // One tick while a program is expected to run: mostly quiet with the door
    // shut, sometimes a stop, a press the sequencer should ignore, or noise.
    task automatic queue_run_tick();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 3) begin
            queue_tick(0, 0, 0, 1, 1, pick_mass());
            queue_tick(0, 0, 0, 0, 1, pick_mass());
        end else if (roll < 8) begin
            queue_tick($urandom_range(1), $urandom_range(1), $urandom_range(1), 0, 1,
                       pick_mass());
            queue_tick(0, 0, 0, 0, 1, pick_mass());
        end else if (roll < 14) begin
            queue_tick($urandom_range(1), $urandom_range(1), $urandom_range(1),
                       $urandom_range(1), $urandom_range(1), $urandom_range(MASS_MAX));
        end else begin
            queue_tick(0, 0, 0, 0, $urandom_range(9) != 0, pick_mass());
        end
    endtask

    // A well-formed session: optional menu moves, enter, a short open-door wait,
    // then a run of program ticks of random length.
    task automatic queue_session();
        int unsigned presses;
        int unsigned opens;
        int unsigned run_len;
        presses = $urandom_range(1) ? $urandom_range(1, 4) : 0;
        opens   = $urandom_range(2);
        run_len = $urandom_range(10, 70);
        repeat (presses) begin
            if ($urandom_range(1)) begin
                queue_tick(1, 0, 0, 0, $urandom_range(1), pick_mass());
            end else begin
                queue_tick(0, 1, 0, 0, $urandom_range(1), pick_mass());
            end
            queue_tick(0, 0, 0, 0, $urandom_range(1), pick_mass());
        end
        queue_tick(0, 0, 1, 0, $urandom_range(1), pick_mass());
        queue_tick(0, 0, 0, 0, 0, pick_mass());
        repeat (opens) queue_tick(0, 0, 0, 0, 0, pick_mass());
        repeat (run_len) queue_run_tick();
    endtask

    // Abort whatever runs and let the stop drain finish, so that the sequencer
    // is back in the menu before the registers change.
    task automatic queue_return_to_menu();
        queue_tick(0, 0, 0, 0, 0, pick_mass());
        queue_tick(0, 0, 0, 1, 0, pick_mass());
        queue_tick(0, 0, 0, 0, 0, pick_mass());
        repeat (shadow_cfg.stop_drain_ticks + 1) begin
            queue_tick(0, 0, 0, 0, $urandom_range(1), $urandom_range(MASS_MAX));
        end
    endtask

    // Wait until every tick is accepted and every prediction is matched, then let
    // the result register of the block drain.
    task automatic wait_drained();
        do begin
            @(posedge aclk);
        end while (sample_queue.size() != 0 || s_tvalid || expected_panel.size() != 0);
        repeat (2) @(posedge aclk);
    endtask

    // Called at a rising edge; the write lands at the next one.
    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, int unsigned value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[CFG_DATA_BITS-1:0];
        case (idx)
            REG_FILL_LOW_LARGE:   shadow_cfg.fill_low_large   = value[THR_BITS-1:0];
            REG_FILL_HIGH_LARGE:  shadow_cfg.fill_high_large  = value[THR_BITS-1:0];
            REG_FILL_LOW_SMALL:   shadow_cfg.fill_low_small   = value[THR_BITS-1:0];
            REG_FILL_HIGH_SMALL:  shadow_cfg.fill_high_small  = value[THR_BITS-1:0];
            REG_TICKS_PER_SECOND: shadow_cfg.ticks_per_second = value[THR_BITS-1:0];
            REG_DISPENSE_SECONDS: shadow_cfg.dispense_seconds = value[SEC_BITS-1:0];
            REG_SETTLE_TICKS:     shadow_cfg.settle_ticks     = value[TICK_BITS-1:0];
            REG_STOP_DRAIN_TICKS: shadow_cfg.stop_drain_ticks = value[TICK_BITS-1:0];
            default: begin
            end
        endcase
        @(posedge aclk);
    endtask

    task automatic configure(int unsigned low_l, int unsigned high_l, int unsigned low_s,
                             int unsigned high_s, int unsigned tps, int unsigned disp,
                             int unsigned settle, int unsigned stop_drain);
        write_reg(REG_FILL_LOW_LARGE, low_l);
        write_reg(REG_FILL_HIGH_LARGE, high_l);
        write_reg(REG_FILL_LOW_SMALL, low_s);
        write_reg(REG_FILL_HIGH_SMALL, high_s);
        write_reg(REG_TICKS_PER_SECOND, tps);
        write_reg(REG_DISPENSE_SECONDS, disp);
        write_reg(REG_SETTLE_TICKS, settle);
        write_reg(REG_STOP_DRAIN_TICKS, stop_drain);
        cfg_wr_en <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------

    initial begin
        int unsigned low_a;
        int unsigned low_b;
        int          goal;

        shadow_cfg.fill_low_large   = RST_FILL_LOW_LARGE;
        shadow_cfg.fill_high_large  = RST_FILL_HIGH_LARGE;
        shadow_cfg.fill_low_small   = RST_FILL_LOW_SMALL;
        shadow_cfg.fill_high_small  = RST_FILL_HIGH_SMALL;
        shadow_cfg.ticks_per_second = RST_TICKS_PER_SECOND;
        shadow_cfg.dispense_seconds = RST_DISPENSE_SECONDS;
        shadow_cfg.settle_ticks     = RST_SETTLE_TICKS;
        shadow_cfg.stop_drain_ticks = RST_STOP_DRAIN_TICKS;
        seq_phase   = PH_MENU;
        seq_prog    = PROG_NORMAL;
        seq_rinse   = 1'b0;
        seq_ticks   = '0;
        seq_secs    = '0;
        seq_buttons = '0;
        seq_lock    = 1'b0;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part under the reset register values, without idling.
        // Menu: up at normal does nothing, even with every button pressed at once.
        queue_tick(0, 0, 0, 0, 0, 0);
        queue_tick(1, 0, 0, 0, 0, 0);
        queue_tick(0, 0, 0, 0, 1, MASS_MAX);
        queue_tick(1, 1, 1, 1, 1, MASS_MAX);
        queue_tick(0, 0, 0, 0, 0, 0);
        // Down twice to quick (down beats enter), then down at quick does nothing.
        queue_tick(0, 1, 0, 0, 0, 0);
        queue_tick(0, 0, 0, 0, 0, 0);
        queue_tick(0, 1, 1, 0, 0, 0);
        queue_tick(0, 0, 0, 0, 0, 0);
        queue_tick(0, 1, 0, 0, 0, 0);
        queue_tick(0, 0, 0, 0, 0, 0);
        // Up back to delicate, then stop in the menu falls back to normal.
        queue_tick(1, 0, 0, 0, 0, 0);
        queue_tick(0, 0, 0, 0, 0, 0);
        queue_tick(0, 0, 0, 1, 0, 0);
        queue_tick(0, 0, 0, 0, 0, 0);
        // Enter beats stop; a held enter gives no second event.
        queue_tick(0, 0, 1, 1, 0, 0);
        queue_tick(0, 0, 1, 0, 0, 0);
        // Door shut at the low mark: fill; overshoot: over; at the high mark: settle.
        queue_tick(0, 0, 0, 0, 1, RST_FILL_LOW_LARGE);
        queue_tick(0, 0, 0, 0, 0, MASS_MAX);
        queue_tick(0, 0, 0, 0, 0, RST_FILL_HIGH_LARGE);
        // Up is ignored during a cycle; stop aborts, and a second stop is ignored.
        queue_tick(1, 0, 0, 0, 1, 0);
        queue_tick(0, 0, 0, 0, 1, 0);
        queue_tick(0, 0, 0, 1, 1, 0);
        queue_tick(0, 0, 0, 0, 1, 0);
        queue_tick(0, 0, 0, 1, 1, 0);
        queue_return_to_menu();
        wait_drained();

        // Random rounds, each with its own registers and idling pattern.
        for (int pass_no = 0; pass_no < ROUNDS; pass_no++) begin
            low_a = $urandom_range(300, 800);
            low_b = $urandom_range(300, 800);
            case (pass_no)
                0: begin
                    // Zero-length settle, dispense and stop drain are skipped.
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    configure(low_a, low_a + $urandom_range(30), low_b,
                              low_b + $urandom_range(30), 1, 0, 0, 0);
                end
                1: begin
                    send_idle_pct  = 69;
                    recv_stall_pct = 0;
                    configure(0, MASS_MAX, 0, 0, 2, $urandom_range(1, 3),
                              $urandom_range(1, 4), $urandom_range(1, 4));
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 69;
                    configure(low_a, low_a + $urandom_range(30), low_b,
                              low_b + $urandom_range(30), $urandom_range(1, 3),
                              $urandom_range(0, 2), $urandom_range(0, 3), 1);
                end
                default: begin
                    // Thresholds drawn independently, so low may lie above high.
                    send_idle_pct  = 21;
                    recv_stall_pct = 21;
                    configure($urandom_range(MASS_MAX), $urandom_range(MASS_MAX),
                              $urandom_range(MASS_MAX), $urandom_range(MASS_MAX), 1,
                              $urandom_range(0, 2), $urandom_range(0, 3),
                              $urandom_range(0, 3));
                end
            endcase
            goal = samples_queued + ROUND_TICKS;
            while (samples_queued < goal) queue_session();
            queue_return_to_menu();
            wait_drained();
        end

        // Largest dispense, settle and stop drain values: the program sits in a long settle,
        // is stopped, and the run ends inside the long stop drain.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        configure(0, MASS_MAX, MASS_MAX, MASS_MAX, 1000, 255, 65535, 65535);
        queue_tick(0, 0, 1, 0, 1, 0);
        queue_tick(0, 0, 0, 0, 1, MASS_MAX / 2);
        repeat (20) queue_tick(0, 0, 0, 0, $urandom_range(1), $urandom_range(MASS_MAX));
        queue_tick(0, 0, 0, 1, 1, 0);
        queue_tick(0, 0, 0, 0, 1, 0);
        repeat (10) queue_tick(0, 0, 0, 0, $urandom_range(1), $urandom_range(MASS_MAX));
        queue_tick(0, 0, 0, 1, 0, 0);
        queue_tick(0, 0, 0, 0, 0, 0);
        wait_drained();

        if (mismatch_count == 0 && expected_panel.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
